[design/rotated_grid_scatter_address_top_assert.svh]
// Assertion macros shared by the scatter address generator RTL.
// Included by the files that carry concurrent checks; needs no other file.
`ifndef ROTATED_GRID_SCATTER_ADDRESS_TOP_ASSERT_SVH
`define ROTATED_GRID_SCATTER_ADDRESS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rgsa_pkg.sv]
// Shared types, field widths and register codes of the scatter address generator.
// Has no dependencies; every other design file but the assert header imports it.
package rgsa_pkg;

	// Field widths fixed by the stream formats.
	localparam int COORD_W    = 6;
	localparam int VAL_W      = 32;
	localparam int DEST_W     = 18;
	localparam int MAT_W      = 36;
	localparam int ENT_W      = 4;
	localparam int SHIFT_W    = 8;
	localparam int GRID_W     = 7;
	localparam int WEIGHT_W   = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PROD_W     = 2 * VAL_W;
	localparam int Q_W        = PROD_W - FRAC_BITS;

	// Affine sum of one axis: 3 * 8 * 63 + 128 fits in 12 signed bits,
	// its magnitude in 11 bits.
	localparam int SUM_W      = 12;
	localparam int MAG_W      = 11;

	// Stream and configuration port widths.
	localparam int S_FIELDS_W = 3 * COORD_W + 2 * VAL_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = DEST_W + 2 * VAL_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = MAT_W;

	// Parameter defaults.
	localparam int MAX_DIM_DEF    = 64;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic {
		MODE_WEIGHTED = 1'b0,
		MODE_COPY     = 1'b1
	} rgsa_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATRIX = 3'd0,
		REG_GRID_X = 3'd1,
		REG_GRID_Y = 3'd2,
		REG_GRID_Z = 3'd3,
		REG_SHIFT  = 3'd4,
		REG_WEIGHT = 3'd5,
		REG_MODE   = 3'd6
	} rgsa_reg_t;

	typedef struct packed {
		logic [MAT_W-1:0]           matrix;
		logic [GRID_W-1:0]          grid_x;
		logic [GRID_W-1:0]          grid_y;
		logic [GRID_W-1:0]          grid_z;
		logic [3*SHIFT_W-1:0]       shift;
		logic signed [WEIGHT_W-1:0] weight;
		rgsa_mode_t                 mode;
	} rgsa_cfg_t;

	localparam logic [MAT_W-1:0]           RST_MATRIX = 36'h1_0001_0001;
	localparam logic [GRID_W-1:0]          RST_GRID   = 7'd64;
	localparam logic [3*SHIFT_W-1:0]       RST_SHIFT  = '0;
	localparam logic signed [WEIGHT_W-1:0] RST_WEIGHT = 32'sh0001_0000;

	// Matrix entry k, row major, as a signed value.
	function automatic logic signed [ENT_W-1:0] mat_entry(input logic [MAT_W-1:0] m,
			input int unsigned k);
		return $signed(m[ENT_W*k +: ENT_W]);
	endfunction

endpackage

[design/rgsa_cfg.sv]
// Configuration register file of the scatter address generator.
// Depends on rgsa_pkg for the register codes and the configuration struct.
module rgsa_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rgsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rgsa_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rgsa_pkg::rgsa_cfg_t              cfg
);
	import rgsa_pkg::*;

	rgsa_cfg_t cfg_q;

	// Every write lands in its register directly, so the port never pushes back.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.matrix <= RST_MATRIX;
			cfg_q.grid_x <= RST_GRID;
			cfg_q.grid_y <= RST_GRID;
			cfg_q.grid_z <= RST_GRID;
			cfg_q.shift  <= RST_SHIFT;
			cfg_q.weight <= RST_WEIGHT;
			cfg_q.mode   <= MODE_WEIGHTED;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MATRIX: cfg_q.matrix <= cfg_data[MAT_W-1:0];
				REG_GRID_X: cfg_q.grid_x <= cfg_data[GRID_W-1:0];
				REG_GRID_Y: cfg_q.grid_y <= cfg_data[GRID_W-1:0];
				REG_GRID_Z: cfg_q.grid_z <= cfg_data[GRID_W-1:0];
				REG_SHIFT:  cfg_q.shift  <= cfg_data[3*SHIFT_W-1:0];
				REG_WEIGHT: cfg_q.weight <= $signed(cfg_data[WEIGHT_W-1:0]);
				REG_MODE:   cfg_q.mode   <= rgsa_mode_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

endmodule

[design/rgsa_affine.sv]
// First pipeline stage: matrix times coordinates plus shift, for all three axes.
// Depends on rgsa_pkg; hands each axis on as magnitude and sign.
module rgsa_affine (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [2:0][rgsa_pkg::COORD_W-1:0]          coord,
	input  logic [rgsa_pkg::MAT_W-1:0]                 matrix,
	input  logic [3*rgsa_pkg::SHIFT_W-1:0]             shift,
	output logic [2:0][rgsa_pkg::MAG_W-1:0]            mag_s1,
	output logic [2:0]                                 neg_s1
);
	import rgsa_pkg::*;

	logic signed [SUM_W-1:0] sum_c [3];
	logic [MAG_W-1:0]        mag_c [3];
	logic [2:0]              neg_c;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = SUM_W'($signed(shift[SHIFT_W*r +: SHIFT_W]));
			for (int k = 0; k < 3; k++) begin
				sum_c[r] = sum_c[r] + SUM_W'(mat_entry(matrix, 3*r + k))
					* SUM_W'($signed({1'b0, coord[k]}));
			end
			neg_c[r] = sum_c[r][SUM_W-1];
			mag_c[r] = neg_c[r] ? MAG_W'(-sum_c[r]) : MAG_W'(sum_c[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				mag_s1[r] <= mag_c[r];
			end
			neg_s1 <= neg_c;
		end
	end

endmodule

[design/rgsa_wrap.sv]
// One slice of the restoring remainder: conditional subtracts of n shifted by
// STEP_HI down to STEP_LO, then a register. Depends on rgsa_pkg.
module rgsa_wrap #(
	parameter int DIM_W   = 7,
	parameter int STEP_HI = 10,
	parameter int STEP_LO = 7
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rgsa_pkg::MAG_W-1:0] rem_in,
	input  logic                       neg_in,
	input  logic [DIM_W-1:0]           n,
	output logic [rgsa_pkg::MAG_W-1:0] rem_q,
	output logic                       neg_q
);
	import rgsa_pkg::*;

	localparam int W = MAG_W + DIM_W;

	logic [W-1:0] r_c;

	always_comb begin
		r_c = W'(rem_in);
		for (int k = STEP_HI; k >= STEP_LO; k--) begin
			if (r_c >= (W'(n) << k)) begin
				r_c = r_c - (W'(n) << k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= r_c[MAG_W-1:0];
			neg_q <= neg_in;
		end
	end

endmodule

[design/rgsa_weight.sv]
// Value path, stages one to three: weight times real part, round half up,
// saturate, or pass the complex value in copy mode. Depends on rgsa_pkg.
module rgsa_weight #(
	parameter int VALUE_BITS = rgsa_pkg::VALUE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en1,
	input  logic                                   en2,
	input  logic                                   en3,
	input  logic signed [rgsa_pkg::WEIGHT_W-1:0]   weight,
	input  rgsa_pkg::rgsa_mode_t                   mode,
	input  logic signed [rgsa_pkg::VAL_W-1:0]      sample_re,
	input  logic signed [rgsa_pkg::VAL_W-1:0]      sample_im,
	output logic signed [rgsa_pkg::VAL_W-1:0]      out_re_s3,
	output logic signed [rgsa_pkg::VAL_W-1:0]      out_im_s3,
	output logic                                   accumulate_s3
);
	import rgsa_pkg::*;

	localparam logic signed [PROD_W-1:0] SAT_HI =
		(PROD_W'(1) <<< (VALUE_BITS - 1)) - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [VAL_W-1:0]  re_s1, im_s1, re_s2, im_s2;
	logic signed [Q_W-1:0]    q_s2;
	logic signed [PROD_W-1:0] rnd_c;
	logic signed [PROD_W-1:0] qx_c;
	logic signed [PROD_W-1:0] sat_c;

	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= PROD_W'(weight) * PROD_W'(sample_re);
			re_s1   <= sample_re;
			im_s1   <= sample_im;
		end
	end

	// Floor of (p + 2^15) / 2^16 is the upper bits of the rounded sum.
	assign rnd_c = prod_s1 + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (en2) begin
			q_s2  <= rnd_c[PROD_W-1:FRAC_BITS];
			re_s2 <= re_s1;
			im_s2 <= im_s1;
		end
	end

	always_comb begin
		qx_c = PROD_W'(q_s2);
		if (qx_c > SAT_HI) begin
			sat_c = SAT_HI;
		end else if (qx_c < SAT_LO) begin
			sat_c = SAT_LO;
		end else begin
			sat_c = qx_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			if (mode == MODE_COPY) begin
				out_re_s3     <= re_s2;
				out_im_s3     <= im_s2;
				accumulate_s3 <= 1'b0;
			end else begin
				out_re_s3     <= sat_c[VAL_W-1:0];
				out_im_s3     <= '0;
				accumulate_s3 <= 1'b1;
			end
		end
	end

endmodule

[design/rotated_grid_scatter_address_top.sv]
// Top level of the rotated grid scatter address generator.
// Depends on rgsa_pkg, rgsa_cfg, rgsa_affine, rgsa_wrap, rgsa_weight and the assert header.
//
// Usage:
// Grid samples arrive as transfers on the s_ stream; each one yields exactly one
// transfer on the m_ stream carrying the flattened destination index, the value
// to store and, in tuser, the accumulate flag (1 add into the destination,
// 0 overwrite). Configuration registers are written over the cfg_ channel,
// which is always ready; write them only while no sample is in flight.
// Throughput is one sample per cycle while the receiver does not stall; each
// sample passes in turn through the six register stages: the affine matrix product
// (with the value multiply alongside), three slices of the remainder reduction (with
// rounding and saturation alongside the first two), then the two multiply-adds that
// flatten the index.
// Reset empties the pipeline and loads the configuration defaults: identity
// matrix, a 64 cube grid, no shift, unity weight and weighted mode.
// When the receiver stalls, the stages hold their contents and bubbles close up
// behind the output register; s_tready falls only once every stage is full, so
// no sample is lost or repeated.
`include "rotated_grid_scatter_address_top_assert.svh"

module rotated_grid_scatter_address_top #(
	parameter int MAX_DIM    = rgsa_pkg::MAX_DIM_DEF,
	parameter int VALUE_BITS = rgsa_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Sample stream. tdata from bit 0: coord_x, coord_y, coord_z, sample_re,
	// sample_im, zero padding.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rgsa_pkg::S_TDATA_W-1:0]    s_tdata,
	// Result stream. tdata from bit 0: dest_index, out_re, out_im, zero padding.
	// tuser: accumulate.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rgsa_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tuser,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rgsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rgsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rgsa_pkg::*;

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int AXW    = $clog2(MAX_DIM);
	localparam int T_W    = 2 * AXW;
	localparam int TS_W   = DIM_W + AXW + 1;
	localparam int IW     = (3 * AXW > DEST_W) ? 3 * AXW : DEST_W;
	// The remainder is split into three slices of roughly equal depth.
	localparam int HI1    = MAG_W - 1;
	localparam int LO1    = (2 * MAG_W) / 3;
	localparam int LO2    = MAG_W / 3;

	// A grid register of zero counts as one, above MAX_DIM as MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [GRID_W-1:0] g);
		if (g == '0) begin
			return DIM_W'(1);
		end else if (32'(g) > MAX_DIM) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(g);
	endfunction

	// Turns |a| mod n back into the non-negative modulo of a signed a.
	function automatic logic [MAG_W-1:0] wrap_fix(input logic [MAG_W-1:0] r,
			input logic neg, input logic [MAG_W-1:0] n);
		if (neg && (r != '0)) begin
			return n - r;
		end
		return r;
	endfunction

	rgsa_cfg_t                cfg;
	logic [2:0][DIM_W-1:0]    dim;

	logic ld1, ld2, ld3, ld4, ld5, ld6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [2:0][COORD_W-1:0]  coord;
	logic signed [VAL_W-1:0]  sample_re, sample_im;

	logic [2:0][MAG_W-1:0]    mag_s1, rem_s2, rem_s3, rem_s4;
	logic [2:0]               neg_s1, neg_s2, neg_s3, neg_s4;

	logic signed [VAL_W-1:0]  re_s3, im_s3, re_s4, im_s4, re_s5, im_s5, re_s6, im_s6;
	logic                     acc_s3, acc_s4, acc_s5, acc_s6;

	logic [AXW-1:0]           x_fix, y_fix, z_fix;
	logic [T_W-1:0]           t_c, t_s5;
	logic [MAG_W-1:0]         zr_s5;
	logic                     zneg_s5;
	logic [IW-1:0]            idx_c;
	logic [DEST_W-1:0]        dest_s6;

	// Configuration registers.
	rgsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign dim[0] = clamp_dim(cfg.grid_x);
	assign dim[1] = clamp_dim(cfg.grid_y);
	assign dim[2] = clamp_dim(cfg.grid_z);

	// Stage loads ripple back from the output: a stage takes new contents when
	// it is empty or when the stage after it is taking its contents.
	assign ld6      = !v_s6 || m_tready;
	assign ld5      = !v_s5 || ld6;
	assign ld4      = !v_s4 || ld5;
	assign ld3      = !v_s3 || ld4;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign s_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= s_tvalid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
			if (ld4) begin
				v_s4 <= v_s3;
			end
			if (ld5) begin
				v_s5 <= v_s4;
			end
			if (ld6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// Unpack the sample transfer.
	assign coord     = s_tdata[3*COORD_W-1:0];
	assign sample_re = $signed(s_tdata[3*COORD_W +: VAL_W]);
	assign sample_im = $signed(s_tdata[3*COORD_W + VAL_W +: VAL_W]);

	// Stage 1: affine transform of the coordinates.
	rgsa_affine u_affine (
		.clk    (clk),
		.en     (ld1),
		.coord  (coord),
		.matrix (cfg.matrix),
		.shift  (cfg.shift),
		.mag_s1 (mag_s1),
		.neg_s1 (neg_s1)
	);

	// Stages 2 to 4: remainder of each axis magnitude by its grid size.
	for (genvar a = 0; a < 3; a++) begin : g_axis
		rgsa_wrap #(.DIM_W(DIM_W), .STEP_HI(HI1), .STEP_LO(LO1)) u_wrap_s2 (
			.clk    (clk),
			.en     (ld2),
			.rem_in (mag_s1[a]),
			.neg_in (neg_s1[a]),
			.n      (dim[a]),
			.rem_q  (rem_s2[a]),
			.neg_q  (neg_s2[a])
		);
		rgsa_wrap #(.DIM_W(DIM_W), .STEP_HI(LO1 - 1), .STEP_LO(LO2)) u_wrap_s3 (
			.clk    (clk),
			.en     (ld3),
			.rem_in (rem_s2[a]),
			.neg_in (neg_s2[a]),
			.n      (dim[a]),
			.rem_q  (rem_s3[a]),
			.neg_q  (neg_s3[a])
		);
		rgsa_wrap #(.DIM_W(DIM_W), .STEP_HI(LO2 - 1), .STEP_LO(0)) u_wrap_s4 (
			.clk    (clk),
			.en     (ld4),
			.rem_in (rem_s3[a]),
			.neg_in (neg_s3[a]),
			.n      (dim[a]),
			.rem_q  (rem_s4[a]),
			.neg_q  (neg_s4[a])
		);
	end

	// Stages 1 to 3: value path, in step with the index path.
	rgsa_weight #(.VALUE_BITS(VALUE_BITS)) u_weight (
		.clk           (clk),
		.en1           (ld1),
		.en2           (ld2),
		.en3           (ld3),
		.weight        (cfg.weight),
		.mode          (cfg.mode),
		.sample_re     (sample_re),
		.sample_im     (sample_im),
		.out_re_s3     (re_s3),
		.out_im_s3     (im_s3),
		.accumulate_s3 (acc_s3)
	);

	// Stage 5: row offset y + Ny * x.
	assign x_fix = AXW'(wrap_fix(rem_s4[0], neg_s4[0], MAG_W'(dim[0])));
	assign y_fix = AXW'(wrap_fix(rem_s4[1], neg_s4[1], MAG_W'(dim[1])));
	assign t_c   = T_W'(TS_W'(y_fix) + TS_W'(dim[1]) * TS_W'(x_fix));

	// Stage 6: flattened index z + Nz * t, kept to the field width.
	assign z_fix = AXW'(wrap_fix(zr_s5, zneg_s5, MAG_W'(dim[2])));
	assign idx_c = IW'(z_fix) + IW'(dim[2]) * IW'(t_s5);

	always_ff @(posedge clk) begin
		if (ld4) begin
			re_s4  <= re_s3;
			im_s4  <= im_s3;
			acc_s4 <= acc_s3;
		end
		if (ld5) begin
			t_s5    <= t_c;
			zr_s5   <= rem_s4[2];
			zneg_s5 <= neg_s4[2];
			re_s5   <= re_s4;
			im_s5   <= im_s4;
			acc_s5  <= acc_s4;
		end
		if (ld6) begin
			dest_s6 <= idx_c[DEST_W-1:0];
			re_s6   <= re_s5;
			im_s6   <= im_s5;
			acc_s6  <= acc_s5;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = M_TDATA_W'({im_s6, re_s6, dest_s6});
	assign m_tuser  = acc_s6;

	// An empty output register must let the whole pipeline move.
	`RGSA_ASSERT_NOW(a_empty_out_ready, clk, arst_n, (!m_tvalid), (s_tready), "s_tready low with empty output")
	// Weighted results always carry a zero imaginary part.
	`RGSA_ASSERT_NOW(a_weighted_im_zero, clk, arst_n, (m_tvalid && m_tuser), (m_tdata[DEST_W+VAL_W +: VAL_W] == '0), "nonzero imaginary part on accumulate")
	// A stalled output keeps the stage behind it occupied.
	`RGSA_ASSERT_NEXT(a_stall_keeps_s5, clk, arst_n, (v_s6 && !m_tready && v_s5), (v_s5), "stage 5 lost its item during a stall")
	// A transfer in with none out adds exactly one item to the pipeline.
	`RGSA_ASSERT_NEXT(a_occupancy_up, clk, arst_n, (s_tvalid && s_tready && !(m_tvalid && m_tready)), ($countones({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6}) == $past($countones({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6})) + 1), "pipeline occupancy did not grow by one")

endmodule

[dv/tb.sv]
// Self-checking testbench for the rotated grid scatter address generator top level.
// Depends on rgsa_pkg and rotated_grid_scatter_address_top; predicts each result in place.
// Directed tests cover the field extremes and special cases, then randomized setups follow.
module tb;
	import rgsa_pkg::*;

	localparam int CLK_HALF = 4;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		logic [COORD_W-1:0]      x;
		logic [COORD_W-1:0]      y;
		logic [COORD_W-1:0]      z;
		logic signed [VAL_W-1:0] re;
		logic signed [VAL_W-1:0] im;
	} grid_sample_t;

	typedef struct {
		logic [DEST_W-1:0] dest;
		logic              acc;
		logic [VAL_W-1:0]  re;
		logic [VAL_W-1:0]  im;
	} scatter_write_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the configuration registers.
	logic [MAT_W-1:0]           shadow_matrix;
	logic [GRID_W-1:0]          shadow_grid [3];
	logic [3*SHIFT_W-1:0]       shadow_shift;
	logic signed [WEIGHT_W-1:0] shadow_weight;
	rgsa_mode_t                 shadow_mode;

	scatter_write_t pending_writes [$];
	int  err_count = 0;
	bit  idle_on = 1'b1;
	bit  long_hold_req = 1'b0;

	rotated_grid_scatter_address_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	function automatic int grid_size(input logic [GRID_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return int'(n);
	endfunction

	// Destination write that one sample produces under the shadow configuration.
	function automatic scatter_write_t scatter_target(input grid_sample_t s);
		int c [3];
		int n [3];
		int pos [3];
		int sum;
		int idx;
		logic signed [ENT_W-1:0]   e;
		logic signed [SHIFT_W-1:0] sh;
		longint prod;
		longint q;
		scatter_write_t w;
		c[0] = int'(s.x);
		c[1] = int'(s.y);
		c[2] = int'(s.z);
		for (int a = 0; a < 3; a++)
			n[a] = grid_size(shadow_grid[a]);
		for (int row = 0; row < 3; row++) begin
			sh = shadow_shift[SHIFT_W*row +: SHIFT_W];
			sum = int'(sh);
			for (int k = 0; k < 3; k++) begin
				e = shadow_matrix[ENT_W*(3*row+k) +: ENT_W];
				sum = sum + int'(e) * c[k];
			end
			// Non-negative remainder, the wrap of a periodic grid.
			pos[row] = sum % n[row];
			if (pos[row] < 0)
				pos[row] += n[row];
		end
		idx = pos[2] + n[2] * (pos[1] + n[1] * pos[0]);
		w.dest = idx[DEST_W-1:0];
		if (shadow_mode == MODE_WEIGHTED) begin
			// Q16.16 product, round half up, saturate to the value range.
			prod = longint'(shadow_weight) * longint'(s.re);
			q = (prod + 64'sd32768) >>> FRAC_BITS;
			if (q > longint'(VAL_MAX))
				q = longint'(VAL_MAX);
			if (q < longint'(VAL_MIN))
				q = longint'(VAL_MIN);
			w.acc = 1'b1;
			w.re = q[VAL_W-1:0];
			w.im = '0;
		end else begin
			w.acc = 1'b0;
			w.re = s.re;
			w.im = s.im;
		end
		return w;
	endfunction

	task automatic apply_reset();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shadow_matrix = RST_MATRIX;
		for (int a = 0; a < 3; a++)
			shadow_grid[a] = RST_GRID;
		shadow_shift = RST_SHIFT;
		shadow_weight = RST_WEIGHT;
		shadow_mode = MODE_WEIGHTED;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MATRIX: shadow_matrix = data[MAT_W-1:0];
			REG_GRID_X: shadow_grid[0] = data[GRID_W-1:0];
			REG_GRID_Y: shadow_grid[1] = data[GRID_W-1:0];
			REG_GRID_Z: shadow_grid[2] = data[GRID_W-1:0];
			REG_SHIFT:  shadow_shift = data[3*SHIFT_W-1:0];
			REG_WEIGHT: shadow_weight = data[WEIGHT_W-1:0];
			REG_MODE:   shadow_mode = rgsa_mode_t'(data[0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offers one sample, with an occasional gap before it, and records its
	// expected write once the transfer completes.
	task automatic send_sample(input grid_sample_t s);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({s.im, s.re, s.z, s.y, s.x});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_writes.push_back(scatter_target(s));
	endtask

	task automatic send_point(input int x, input int y, input int z,
			input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im);
		grid_sample_t s;
		s.x = COORD_W'(x);
		s.y = COORD_W'(y);
		s.z = COORD_W'(z);
		s.re = re;
		s.im = im;
		send_sample(s);
	endtask

	// Registers may only change once the pipeline is empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_point(0, 0, 0, 32'h0, 32'h0);
		send_point(63, 63, 63, VAL_MAX, VAL_MAX);
		send_point(63, 0, 21, VAL_MIN, VAL_MIN);
		send_point(42, 63, 0, 32'hFFFF_FFFF, 32'h1234_5678);
		send_point(21, 42, 63, 32'h0001_8000, 32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_weighted_rounding();
		// Half a unit: ties round up, including the negative ones.
		write_reg(REG_WEIGHT, 36'h0_0000_8000);
		send_point(1, 2, 3, 32'h1, 32'h0);
		send_point(4, 5, 6, 32'hFFFF_FFFF, 32'h0);
		send_point(7, 8, 9, 32'h3, 32'h0);
		drain();
		// Both most negative: the product overflows high and saturates.
		write_reg(REG_WEIGHT, 36'h0_8000_0000);
		send_point(10, 11, 12, VAL_MIN, 32'h0);
		send_point(13, 14, 15, VAL_MAX, 32'h0);
		drain();
		write_reg(REG_WEIGHT, 36'h0_7FFF_FFFF);
		send_point(16, 17, 18, VAL_MAX, 32'h0);
		send_point(19, 20, 21, VAL_MIN, 32'h0);
		drain();
		write_reg(REG_WEIGHT, 36'h0_0000_0000);
		send_point(22, 23, 24, VAL_MAX, VAL_MAX);
		drain();
		write_reg(REG_WEIGHT, 36'h0_FFFF_FFFF);
		send_point(25, 26, 27, 32'h1, 32'h0);
		drain();
	endtask

	task automatic test_copy_mode();
		write_reg(REG_MODE, 36'h0_0000_0001);
		send_point(63, 63, 63, VAL_MIN, VAL_MAX);
		send_point(0, 0, 0, VAL_MAX, VAL_MIN);
		send_point(31, 32, 33, 32'hDEAD_BEEF, 32'h0F0F_F0F0);
		drain();
		write_reg(REG_MODE, 36'h0_0000_0000);
	endtask

	task automatic test_grid_edges();
		// A zero size acts as one, oversize acts as the maximum, and bits
		// beyond a register's width are dropped.
		write_reg(REG_GRID_X, 36'h0_0000_0000);
		write_reg(REG_GRID_Y, 36'hF_FFFF_FFFF);
		write_reg(REG_GRID_Z, 36'h0_0000_0041);
		write_reg(REG_MATRIX, 36'h8_8888_8888);
		write_reg(REG_SHIFT, 36'hF_FF80_8080);
		send_point(63, 63, 63, 32'h0000_0100, 32'h0);
		drain();
		write_reg(REG_GRID_X, 36'h0_0000_0040);
		write_reg(REG_MATRIX, 36'h7_7777_7777);
		write_reg(REG_SHIFT, 36'h0_007F_7F7F);
		send_point(63, 63, 63, 32'h0000_0100, 32'h0);
		drain();
		// Writes to an unmapped index must leave every register alone.
		write_reg(REG_UNMAPPED, 36'hF_FFFF_FFFF);
		write_reg(REG_GRID_X, 36'h0_0000_0001);
		write_reg(REG_GRID_Y, 36'h0_0000_0001);
		write_reg(REG_GRID_Z, 36'h0_0000_0001);
		send_point(37, 12, 55, 32'h0001_0000, 32'h0);
		drain();
	endtask

	// Picks a new setup: mostly signed permutation matrices (grid rotations and
	// reflections), sometimes arbitrary ones, with grid sizes at or past the edges at times.
	task automatic randomize_setup();
		logic [MAT_W-1:0] mat;
		logic [CFG_DATA_W-1:0] val;
		int p [3];
		bit arbitrary;
		arbitrary = ($urandom_range(0, 3) == 0);
		p[0] = $urandom_range(0, 2);
		p[1] = (p[0] + 1 + $urandom_range(0, 1)) % 3;
		p[2] = 3 - p[0] - p[1];
		for (int row = 0; row < 3; row++)
			for (int k = 0; k < 3; k++)
				if (arbitrary)
					mat[ENT_W*(3*row+k) +: ENT_W] = ENT_W'($urandom_range(0, 15));
				else if (k == p[row])
					mat[ENT_W*(3*row+k) +: ENT_W] = $urandom_range(0, 1) ? 4'hF : 4'h1;
				else
					mat[ENT_W*(3*row+k) +: ENT_W] = 4'h0;
		write_reg(REG_MATRIX, mat);
		for (int a = 0; a < 3; a++) begin
			val = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
				: CFG_DATA_W'($urandom_range(1, 64));
			write_reg(CFG_IDX_W'(REG_GRID_X + a), val);
		end
		write_reg(REG_SHIFT, CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF)));
		if ($urandom_range(0, 1))
			val = CFG_DATA_W'($urandom);
		else
			val = CFG_DATA_W'(32'($urandom_range(0, 32'h3_FFFF) - 32'h2_0000));
		write_reg(REG_WEIGHT, val);
		write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
	endtask

	task automatic send_random(input int count);
		grid_sample_t s;
		for (int i = 0; i < count; i++) begin
			s.x = COORD_W'($urandom);
			s.y = COORD_W'($urandom);
			s.z = COORD_W'($urandom);
			s.re = $urandom;
			s.im = $urandom;
			case ($urandom_range(0, 15))
				0: s.re = VAL_MAX;
				1: s.re = VAL_MIN;
				2: s.re = '0;
				3: s.re = '1;
				default: ;
			endcase
			send_sample(s);
		end
	endtask

	task automatic test_random_setups();
		for (int phase = 0; phase < 8; phase++) begin
			randomize_setup();
			idle_on = (phase == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
			send_random(250);
			drain();
		end
	endtask

	// The receiver holds off long enough for every stage to fill, while
	// samples keep coming; the sender must see s_tready fall and wait.
	task automatic test_backpressure();
		idle_on = 1'b0;
		long_hold_req = 1'b1;
		send_random(60);
		drain();
	endtask

	// Receiver: random bursts of stalls, plus one long hold on request.
	always @(posedge clk) begin
		static int stall_left = 0;
		static int hold_left = 0;
		static bit hold_taken = 1'b0;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 300;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 10) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			err_count++;
		end
	endtask

	// Compares every result transfer with the oldest expected write.
	always @(posedge clk) begin
		scatter_write_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_writes.size() == 0) begin
				$error("result transfer with no sample outstanding: tdata %0h", m_tdata);
				err_count++;
			end else begin
				w = pending_writes.pop_front();
				check_field("dest_index", VAL_W'(w.dest), VAL_W'(m_tdata[DEST_W-1:0]));
				check_field("accumulate", VAL_W'(w.acc), VAL_W'(m_tuser));
				check_field("out_re", w.re, m_tdata[DEST_W +: VAL_W]);
				check_field("out_im", w.im, m_tdata[DEST_W+VAL_W +: VAL_W]);
			end
		end
	end

	initial begin
		apply_reset();
		test_reset_defaults();
		test_weighted_rounding();
		test_copy_mode();
		test_grid_edges();
		test_backpressure();
		idle_on = 1'b1;
		test_random_setups();
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#(2 * CLK_HALF * 1000000);
		$display("status: fail");
		$finish;
	end

endmodule
